[rtl/xed_pkg.sv]
`default_nettype none

package xed_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CODE_W = 21;
  localparam logic [CODE_W-1:0] CODE_LIMIT = 21'h110000;
  localparam logic [CODE_W-1:0] CODE_2B    = 21'h000080;
  localparam logic [CODE_W-1:0] CODE_3B    = 21'h000800;
  localparam logic [CODE_W-1:0] CODE_4B    = 21'h010000;

  localparam logic [7:0] CH_AMP = 8'h26;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE     = 3'd0;
  localparam err_t ERR_BAD_NAME = 3'd1;
  localparam err_t ERR_NO_SEMI  = 3'd2;
  localparam err_t ERR_RANGE    = 3'd3;
  localparam err_t ERR_UNTERM   = 3'd4;

  typedef enum logic [3:0] {
    PH_PLAIN,
    PH_AMP,
    PH_A,
    PH_AM,
    PH_AP,
    PH_APO,
    PH_Q,
    PH_QU,
    PH_T,
    PH_SEMI,
    PH_HASH,
    PH_DIGITS
  } phase_t;

  // BYTE: one byte; AMP2: '&' then a byte; UTF8: encoded code point;
  // FLAG: one result without a byte, carries the error code
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_AMP2,
    CMD_UTF8,
    CMD_FLAG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [1:0]        last_idx;
    logic [CODE_W-1:0] data;
    err_t              err;
    logic              eov;
  } xed_cmd_t;

endpackage

`default_nettype wire

[rtl/xed_front.sv]
`default_nettype none

module xed_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic             q_full,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_end_of_value,
  output logic                  cmd_push,
  output xed_pkg::xed_cmd_t     cmd
);

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam int unsigned SUM_W = xed_pkg::CODE_W + 5;

  xed_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [xed_pkg::CODE_W-1:0] acc_r, acc_nxt, acc_step;
  logic ovf_r, ovf_nxt, ovf_step;
  logic hex_r, hex_nxt, hex_step;
  logic drop_r, drop_nxt;

  logic accept;
  logic use_hex;
  logic dig_ok;
  logic [3:0] dig_val;
  logic [SUM_W-1:0] acc_prod;
  logic [SUM_W-1:0] acc_sum;
  logic sum_big;

  xed_pkg::err_t err_raw;
  logic pre_vld;
  xed_pkg::cmd_kind_t pre_kind;
  logic [7:0] pre_byte;
  logic cmd_vld;

  assign accept = in_push && !q_full;

  assign use_hex = (phase_r == xed_pkg::PH_DIGITS) && hex_r;

  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_byte - 8'h30);
    end else if (use_hex && in_byte >= 8'h41 && in_byte <= 8'h46) begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_byte - 8'h37);
    end else if (use_hex && in_byte >= 8'h61 && in_byte <= 8'h66) begin
      dig_ok  = 1'b1;
      dig_val = 4'(in_byte - 8'h57);
    end
  end

  always_comb begin
    if (use_hex) begin
      acc_prod = {1'b0, acc_r, 4'b0000};
    end else begin
      acc_prod = {2'b00, acc_r, 3'b000} + {4'b0000, acc_r, 1'b0};
    end
    acc_sum = acc_prod + SUM_W'(dig_val);
    sum_big = acc_sum >= SUM_W'(xed_pkg::CODE_LIMIT);
  end

  // per-byte decode of the reference grammar
  always_comb begin
    phase_step = phase_r;
    acc_step   = acc_r;
    ovf_step   = ovf_r;
    hex_step   = hex_r;
    err_raw    = xed_pkg::ERR_NONE;
    pre_vld    = 1'b0;
    pre_kind   = xed_pkg::CMD_BYTE;
    pre_byte   = in_byte;
    unique case (phase_r)
      xed_pkg::PH_AMP: begin
        if (in_byte == CH_A) begin
          phase_step = xed_pkg::PH_A;
        end else if (in_byte == CH_G) begin
          acc_step   = xed_pkg::CODE_W'(CH_GT);
          phase_step = xed_pkg::PH_T;
        end else if (in_byte == CH_L) begin
          acc_step   = xed_pkg::CODE_W'(CH_LT);
          phase_step = xed_pkg::PH_T;
        end else if (in_byte == CH_Q) begin
          phase_step = xed_pkg::PH_Q;
        end else if (in_byte == CH_HASH) begin
          acc_step   = '0;
          ovf_step   = 1'b0;
          phase_step = xed_pkg::PH_HASH;
        end else if (in_byte == xed_pkg::CH_AMP) begin
          pre_vld    = 1'b1;
          pre_kind   = xed_pkg::CMD_BYTE;
          pre_byte   = xed_pkg::CH_AMP;
          phase_step = xed_pkg::PH_AMP;
        end else begin
          pre_vld    = 1'b1;
          pre_kind   = xed_pkg::CMD_AMP2;
          phase_step = xed_pkg::PH_PLAIN;
        end
      end
      xed_pkg::PH_A: begin
        if (in_byte == CH_M) begin
          phase_step = xed_pkg::PH_AM;
        end else if (in_byte == CH_P) begin
          phase_step = xed_pkg::PH_AP;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_AM: begin
        if (in_byte == CH_P) begin
          acc_step   = xed_pkg::CODE_W'(xed_pkg::CH_AMP);
          phase_step = xed_pkg::PH_SEMI;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_AP: begin
        if (in_byte == CH_O) begin
          phase_step = xed_pkg::PH_APO;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_APO: begin
        if (in_byte == CH_S) begin
          acc_step   = xed_pkg::CODE_W'(CH_APOS);
          phase_step = xed_pkg::PH_SEMI;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_Q: begin
        if (in_byte == CH_U) begin
          phase_step = xed_pkg::PH_QU;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_QU: begin
        if (in_byte == CH_O) begin
          acc_step   = xed_pkg::CODE_W'(CH_QUOT);
          phase_step = xed_pkg::PH_T;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_T: begin
        if (in_byte == CH_T) begin
          phase_step = xed_pkg::PH_SEMI;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_SEMI: begin
        if (in_byte == CH_SEMI) begin
          pre_vld    = 1'b1;
          pre_kind   = xed_pkg::CMD_BYTE;
          pre_byte   = acc_r[7:0];
          acc_step   = '0;
          phase_step = xed_pkg::PH_PLAIN;
        end else begin
          err_raw = xed_pkg::ERR_BAD_NAME;
        end
      end
      xed_pkg::PH_HASH, xed_pkg::PH_DIGITS: begin
        phase_step = xed_pkg::PH_DIGITS;
        if (phase_r == xed_pkg::PH_HASH && in_byte == CH_X) begin
          hex_step = 1'b1;
        end else begin
          if (phase_r == xed_pkg::PH_HASH) begin
            hex_step = 1'b0;
          end
          if (dig_ok) begin
            if (!ovf_r) begin
              if (sum_big) begin
                ovf_step = 1'b1;
                acc_step = xed_pkg::CODE_LIMIT;
              end else begin
                acc_step = acc_sum[xed_pkg::CODE_W-1:0];
              end
            end
          end else if (in_byte != CH_SEMI) begin
            err_raw = xed_pkg::ERR_NO_SEMI;
          end else if (ovf_r) begin
            err_raw = xed_pkg::ERR_RANGE;
          end else begin
            pre_vld    = 1'b1;
            pre_kind   = xed_pkg::CMD_UTF8;
            phase_step = xed_pkg::PH_PLAIN;
          end
        end
      end
      default: begin
        phase_step = xed_pkg::PH_PLAIN;
        if (in_byte == xed_pkg::CH_AMP) begin
          phase_step = xed_pkg::PH_AMP;
        end else begin
          pre_vld  = 1'b1;
          pre_kind = xed_pkg::CMD_BYTE;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    hex_nxt   = hex_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (in_end_of_value) begin
        phase_nxt = xed_pkg::PH_PLAIN;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        hex_nxt   = 1'b0;
        drop_nxt  = 1'b0;
      end else if (!drop_r) begin
        acc_nxt = acc_step;
        ovf_nxt = ovf_step;
        hex_nxt = hex_step;
        if (err_raw != xed_pkg::ERR_NONE) begin
          phase_nxt = xed_pkg::PH_PLAIN;
          drop_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_step;
        end
      end
    end
  end

  // transaction toward the back end
  always_comb begin
    cmd_vld      = 1'b0;
    cmd.kind     = pre_kind;
    cmd.last_idx = 2'd0;
    cmd.data     = xed_pkg::CODE_W'(pre_byte);
    cmd.err      = xed_pkg::ERR_NONE;
    cmd.eov      = in_end_of_value;
    if (drop_r) begin
      if (in_end_of_value) begin
        cmd_vld  = 1'b1;
        cmd.kind = xed_pkg::CMD_FLAG;
      end
    end else if (err_raw != xed_pkg::ERR_NONE) begin
      cmd_vld  = 1'b1;
      cmd.kind = xed_pkg::CMD_FLAG;
      cmd.err  = err_raw;
    end else if (in_end_of_value && phase_step == xed_pkg::PH_AMP) begin
      cmd_vld  = 1'b1;
      cmd.data = xed_pkg::CODE_W'(xed_pkg::CH_AMP);
      if (pre_vld) begin
        cmd.kind     = xed_pkg::CMD_AMP2;
        cmd.last_idx = 2'd1;
      end else begin
        cmd.kind = xed_pkg::CMD_BYTE;
      end
    end else if (in_end_of_value && phase_step != xed_pkg::PH_PLAIN) begin
      cmd_vld  = 1'b1;
      cmd.kind = xed_pkg::CMD_FLAG;
      cmd.err  = xed_pkg::ERR_UNTERM;
    end else if (pre_vld) begin
      cmd_vld = 1'b1;
      case (pre_kind)
        xed_pkg::CMD_AMP2: begin
          cmd.last_idx = 2'd1;
        end
        xed_pkg::CMD_UTF8: begin
          cmd.data = acc_r;
          if (acc_r < xed_pkg::CODE_2B) begin
            cmd.last_idx = 2'd0;
          end else if (acc_r < xed_pkg::CODE_3B) begin
            cmd.last_idx = 2'd1;
          end else if (acc_r < xed_pkg::CODE_4B) begin
            cmd.last_idx = 2'd2;
          end else begin
            cmd.last_idx = 2'd3;
          end
        end
        default: begin
          cmd.last_idx = 2'd0;
        end
      endcase
    end
  end

  assign cmd_push = accept && cmd_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= xed_pkg::PH_PLAIN;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      hex_r   <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      hex_r   <= hex_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/xed_queue.sv]
`default_nettype none

module xed_queue #(
  parameter int unsigned DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire xed_pkg::xed_cmd_t wr_data,
  output logic                   q_full,
  input  wire logic              rd_en,
  output logic                   q_empty,
  output xed_pkg::xed_cmd_t      rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  xed_pkg::xed_cmd_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_wr, do_rd;

  assign q_full  = cnt_r == CW'(DEPTH);
  assign q_empty = cnt_r == '0;
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/xed_back.sv]
`default_nettype none

module xed_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire xed_pkg::xed_cmd_t q_head,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [7:0]             out_byte,
  output logic                   out_byte_valid,
  output logic [2:0]             out_error_code,
  output logic                   out_value_done,
  output logic                   out_last_of_run
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       bval_r;
  xed_pkg::err_t err_r;
  logic       done_r, last_r;

  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;
  logic       sel_bval;
  xed_pkg::err_t sel_err;
  logic [xed_pkg::CODE_W-1:0] code;

  assign code    = q_head.data;
  assign load    = !q_empty && (!vld_r || out_pop);
  assign is_last = idx_r == q_head.last_idx;
  assign q_pop   = load && is_last;

  always_comb begin
    sel_byte = q_head.data[7:0];
    sel_bval = 1'b1;
    sel_err  = xed_pkg::ERR_NONE;
    unique case (q_head.kind)
      xed_pkg::CMD_BYTE: begin
        sel_byte = q_head.data[7:0];
      end
      xed_pkg::CMD_AMP2: begin
        sel_byte = (idx_r == 2'd0) ? xed_pkg::CH_AMP : q_head.data[7:0];
      end
      xed_pkg::CMD_UTF8: begin
        case ({q_head.last_idx, idx_r})
          4'b00_00: sel_byte = {1'b0, code[6:0]};
          4'b01_00: sel_byte = xed_pkg::UTF8_LEAD2 | {3'b000, code[10:6]};
          4'b10_00: sel_byte = xed_pkg::UTF8_LEAD3 | {4'b0000, code[15:12]};
          4'b11_00: sel_byte = xed_pkg::UTF8_LEAD4 | {5'b00000, code[20:18]};
          4'b11_01: sel_byte = xed_pkg::UTF8_CONT | {2'b00, code[17:12]};
          4'b10_01, 4'b11_10: sel_byte = xed_pkg::UTF8_CONT | {2'b00, code[11:6]};
          default: sel_byte = xed_pkg::UTF8_CONT | {2'b00, code[5:0]};
        endcase
      end
      xed_pkg::CMD_FLAG: begin
        sel_byte = 8'h00;
        sel_bval = 1'b0;
        sel_err  = q_head.err;
      end
      default: begin
        sel_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      bval_r <= sel_bval;
      err_r  <= sel_err;
      done_r <= is_last && q_head.eov;
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_empty       = !vld_r;
  assign out_byte        = byte_r;
  assign out_byte_valid  = bval_r;
  assign out_error_code  = err_r;
  assign out_value_done  = done_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire

[rtl/xml_entity_to_utf8_decoder_top.sv]
// XML character reference decoder, escaped value bytes in, UTF-8 bytes out.
// Input side is a queue write port: present in_byte / in_end_of_value with
// push; the byte is taken on a clock edge where push is high and full low.
// Result side is a queue read port: while empty is low the oldest result
// sits on the out_ ports; pop takes it. Each input yields zero to four
// results; out_last_of_run marks the last one of an input, out_value_done
// the last one of the value's final byte. Errors give one result with
// out_byte_valid low and the code; the rest of that value is discarded,
// its final byte giving only a byteless result with no error code.
// Throughput: one input per cycle while each gives at most one result and
// pop is high; the single output stage emits one result per cycle while
// pop is high, so an input that expands to more than one byte holds the
// back end, and the command queue (QUEUE_DEPTH entries) absorbs that
// before full rises. When the receiver stalls, the output holds, the queue
// fills and full rises; nothing is lost. Synchronous reset clears the
// decode state, the queue and the output stage; empty is high and full low
// after reset.
`default_nettype none

module xml_entity_to_utf8_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_value,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic [2:0]      out_error_code,
  output logic            out_value_done,
  output logic            out_last_of_run
);

  logic              cmd_push;
  xed_pkg::xed_cmd_t cmd;
  logic              q_empty;
  logic              q_pop;
  xed_pkg::xed_cmd_t q_head;

  xed_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .q_full          (full),
    .in_byte         (in_byte),
    .in_end_of_value (in_end_of_value),
    .cmd_push        (cmd_push),
    .cmd             (cmd)
  );

  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .q_full  (full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_head)
  );

  xed_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_empty       (empty),
    .out_pop         (pop),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_error_code  (out_error_code),
    .out_value_done  (out_value_done),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

[rtl/xed_checker.sv]
`default_nettype none

module xed_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic [2:0] out_error_code,
  input wire logic       out_value_done,
  input wire logic       out_last_of_run
);

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_value_done) |-> out_last_of_run)
    else $error("value_done without last_of_run");

  a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_error_code != xed_pkg::ERR_NONE) |-> (!out_byte_valid && out_byte == 8'h00))
    else $error("error transaction carries a byte");

  a_flag_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_byte_valid) |-> (out_last_of_run && out_byte == 8'h00))
    else $error("byteless transaction not alone in its run");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_error_code == xed_pkg::ERR_NONE || out_error_code == xed_pkg::ERR_BAD_NAME ||
                out_error_code == xed_pkg::ERR_NO_SEMI || out_error_code == xed_pkg::ERR_RANGE ||
                out_error_code == xed_pkg::ERR_UNTERM))
    else $error("error code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind xml_entity_to_utf8_decoder_top xed_checker u_xed_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .empty           (empty),
  .pop             (pop),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_error_code  (out_error_code),
  .out_value_done  (out_value_done),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire
